>>> hw/rtl/dtf_pkg.sv
// Shared types and constants for the decimal text to fixed-point converter.
package dtf_pkg;

    // Default fixed-point format, Q16.16
    localparam int INT_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;

    // Fraction weight is Q0.24; the fraction sum needs one extra bit for rounding carry
    localparam int WEIGHT_W = 24;
    localparam int FSUM_W   = 25;

    localparam logic [WEIGHT_W-1:0]   TENTH_Q24  = 24'd1677722;
    localparam logic [2*WEIGHT_W-1:0] WEIGHT_RND = 48'h00_0000_800000;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_SIGN  = 5'b00010,
        PH_INT   = 5'b00100,
        PH_FRAC  = 5'b01000,
        PH_ERR   = 5'b10000
    } t_phase;

    // Parse status handed from the scanner to the result formatter
    typedef struct packed {
        logic negative;
        logic saturated;
        logic dot_pending;
        logic bad;
    } t_flags;

endpackage

>>> hw/rtl/dtf_state.sv
// Character scanner: phase tracking, integer and fraction accumulation.
module dtf_state #(
    parameter int INT_BITS = dtf_pkg::INT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [7:0]                  i_char,
    output dtf_pkg::t_flags             o_flags,
    output logic [INT_BITS-1:0]         o_magnitude,
    output logic [dtf_pkg::FSUM_W-1:0]  o_frac_sum
);

    localparam int MW = INT_BITS + 4;
    localparam int WW = dtf_pkg::WEIGHT_W;
    localparam int FW = dtf_pkg::FSUM_W;
    localparam logic [INT_BITS-1:0] CAP = INT_BITS'(1) << (INT_BITS - 1);

    dtf_pkg::t_phase       r_phase, n_phase;
    logic [INT_BITS-1:0]   r_magnitude, n_magnitude;
    logic [WW-1:0]         r_weight, n_weight;
    logic [FW-1:0]         r_frac_sum, n_frac_sum;
    logic                  r_negative, n_negative;
    logic                  r_saturated, n_saturated;
    logic                  r_dot, n_dot;

    logic [7:0]            digit_off;
    logic [3:0]            digit;
    logic                  is_digit;
    logic [MW-1:0]         mag_wide;
    logic [WW+3:0]         frac_prod;
    logic [2*WW-1:0]       weight_prod;

    assign digit_off   = i_char - dtf_pkg::CH_ZERO;
    assign digit       = digit_off[3:0];
    assign is_digit    = (i_char >= dtf_pkg::CH_ZERO) && (i_char <= dtf_pkg::CH_NINE);
    assign mag_wide    = (MW'(r_magnitude) << 3) + (MW'(r_magnitude) << 1) + MW'(digit);
    assign frac_prod   = (WW+4)'(r_weight) * (WW+4)'(digit);
    assign weight_prod = (2*WW)'(r_weight) * (2*WW)'(dtf_pkg::TENTH_Q24) + dtf_pkg::WEIGHT_RND;

    always_comb begin
        n_phase     = r_phase;
        n_magnitude = r_magnitude;
        n_weight    = r_weight;
        n_frac_sum  = r_frac_sum;
        n_negative  = r_negative;
        n_saturated = r_saturated;
        n_dot       = r_dot;
        if (i_char == dtf_pkg::CH_NUL) begin
            // end of string: back to the start of a new one
            n_phase     = dtf_pkg::PH_START;
            n_magnitude = '0;
            n_weight    = dtf_pkg::TENTH_Q24;
            n_frac_sum  = '0;
            n_negative  = 1'b0;
            n_saturated = 1'b0;
            n_dot       = 1'b0;
        end else if (r_phase != dtf_pkg::PH_ERR) begin
            if (is_digit) begin
                if (r_phase == dtf_pkg::PH_FRAC) begin
                    n_frac_sum = r_frac_sum + FW'(frac_prod);
                    n_weight   = weight_prod[2*WW-1:WW];
                    n_dot      = 1'b0;
                end else begin
                    n_phase = dtf_pkg::PH_INT;
                    if (!r_saturated) begin
                        // hold the integer part at its cap once reached
                        if (mag_wide >= MW'(CAP)) begin
                            n_magnitude = CAP;
                            n_saturated = 1'b1;
                        end else begin
                            n_magnitude = INT_BITS'(mag_wide);
                        end
                    end
                end
            end else if (i_char == dtf_pkg::CH_MINUS) begin
                if (r_phase == dtf_pkg::PH_START) begin
                    n_phase    = dtf_pkg::PH_SIGN;
                    n_negative = 1'b1;
                end else begin
                    n_phase = dtf_pkg::PH_ERR;
                end
            end else if (i_char == dtf_pkg::CH_DOT) begin
                if (r_phase == dtf_pkg::PH_SIGN || r_phase == dtf_pkg::PH_INT) begin
                    n_phase = dtf_pkg::PH_FRAC;
                    n_dot   = 1'b1;
                end else begin
                    n_phase = dtf_pkg::PH_ERR;
                end
            end else begin
                n_phase = dtf_pkg::PH_ERR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dtf_pkg::PH_START;
            r_magnitude <= '0;
            r_weight    <= dtf_pkg::TENTH_Q24;
            r_frac_sum  <= '0;
            r_negative  <= 1'b0;
            r_saturated <= 1'b0;
            r_dot       <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_magnitude <= n_magnitude;
            r_weight    <= n_weight;
            r_frac_sum  <= n_frac_sum;
            r_negative  <= n_negative;
            r_saturated <= n_saturated;
            r_dot       <= n_dot;
        end
    end

    assign o_flags.negative    = r_negative;
    assign o_flags.saturated   = r_saturated;
    assign o_flags.dot_pending = r_dot;
    assign o_flags.bad         = (r_phase == dtf_pkg::PH_ERR);
    assign o_magnitude         = r_magnitude;
    assign o_frac_sum          = r_frac_sum;

endmodule

>>> hw/rtl/dtf_finish.sv
// Result formatter: fraction rounding, saturation and sign for one string.
module dtf_finish #(
    parameter int INT_BITS  = dtf_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS = dtf_pkg::FRAC_BITS_DEF
) (
    input  dtf_pkg::t_flags             i_flags,
    input  logic [INT_BITS-1:0]         i_magnitude,
    input  logic [dtf_pkg::FSUM_W-1:0]  i_frac_sum,
    output logic signed [31:0]          o_value,
    output logic                        o_error,
    output logic                        o_overflow
);

    localparam int QW = INT_BITS + FRAC_BITS;
    localparam int OW = (QW > 32) ? QW : 32;
    localparam int FW = dtf_pkg::FSUM_W;
    localparam logic [QW-1:0] TOP = QW'(1) << (QW - 1);

    logic [QW-1:0] fr;
    logic [QW-1:0] mag_int;
    logic [QW-1:0] sum;
    logic [QW-1:0] limit;
    logic [QW-1:0] mag;
    logic          ovf;
    logic [OW-1:0] ext;

    generate
        if (FRAC_BITS < dtf_pkg::WEIGHT_W) begin : g_round
            localparam int SH = dtf_pkg::WEIGHT_W - FRAC_BITS;
            logic [FW:0] rnd;
            // round half up from Q0.24 to the output fraction width
            assign rnd = {1'b0, i_frac_sum} + ((FW+1)'(1) << (SH - 1));
            assign fr  = QW'(rnd >> SH);
        end else begin : g_widen
            assign fr = QW'(i_frac_sum) << (FRAC_BITS - dtf_pkg::WEIGHT_W);
        end
    endgenerate

    assign mag_int = QW'(i_magnitude) << FRAC_BITS;
    assign sum     = mag_int + fr;
    assign limit   = i_flags.negative ? TOP : TOP - QW'(1);

    always_comb begin
        mag = sum;
        ovf = 1'b0;
        if (i_flags.saturated || (sum > limit)) begin
            mag = limit;
            ovf = 1'b1;
        end
        ext = OW'(mag);
        if (i_flags.negative) begin
            ext = -ext;
        end
        if (i_flags.bad || i_flags.dot_pending) begin
            o_value    = '0;
            o_error    = 1'b1;
            o_overflow = 1'b0;
        end else begin
            o_value    = ext[31:0];
            o_error    = 1'b0;
            o_overflow = ovf;
        end
    end

endmodule

>>> hw/rtl/decimal_text_to_fixed.sv
// Top level of the streaming decimal text to signed fixed-point converter.
//
// Feed one character per transaction on the input channel; a NUL closes the
// string and produces exactly one result transaction carrying the value in
// signed Q(INT_BITS).(FRAC_BITS) form (low 32 bits), an error flag and an
// overflow flag. Accepted syntax: optional leading minus, integer digits, at
// most one dot followed by fraction digits ("-.5" is fine, ".5", "5." and
// "+5" are errors). Empty text or a lone minus yields zero. An integer part
// that reaches 2^(INT_BITS-1) saturates the value and sets overflow; an error
// forces value and overflow to zero. The block takes one character per clock
// cycle with no bubbles: each character passes through an input register and
// the scan logic (a 24x24 constant multiply for the fraction weight and a 4x24
// digit product), and the result of a NUL is captured in an output register
// when the NUL leaves the input register. The output register decouples the
// two channels, so characters of the next string keep flowing while a result
// waits; only a NUL stalls, and only while the previous result is untaken.
module decimal_text_to_fixed #(
    parameter int INT_BITS  = dtf_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS = dtf_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value,
    output logic               o_error,
    output logic               o_overflow
);

    // input stage
    logic        r_in_vld;
    logic [7:0]  r_char;

    // output stage
    logic               r_out_vld;
    logic signed [31:0] r_value;
    logic               r_error;
    logic               r_overflow;

    logic                         out_free;
    logic                         is_nul;
    logic                         step;
    logic                         in_acc;
    dtf_pkg::t_flags              flags;
    logic [INT_BITS-1:0]          magnitude;
    logic [dtf_pkg::FSUM_W-1:0]   frac_sum;
    logic signed [31:0]           n_value;
    logic                         n_error;
    logic                         n_overflow;

    // The output slot is free when empty or being drained this cycle.
    assign out_free = !r_out_vld || i_out_ready;
    assign is_nul   = (r_char == dtf_pkg::CH_NUL);

    // Advance the held character: ordinary characters always go, a NUL only
    // when its result has somewhere to land.
    assign step       = r_in_vld && (!is_nul || out_free);
    assign o_in_ready = !r_in_vld || step;
    assign in_acc     = i_in_valid && o_in_ready;

    dtf_state #(
        .INT_BITS (INT_BITS)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_char      (r_char),
        .o_flags     (flags),
        .o_magnitude (magnitude),
        .o_frac_sum  (frac_sum)
    );

    // Format from the state as it stands before the NUL clears it.
    dtf_finish #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_finish (
        .i_flags     (flags),
        .i_magnitude (magnitude),
        .i_frac_sum  (frac_sum),
        .o_value     (n_value),
        .o_error     (n_error),
        .o_overflow  (n_overflow)
    );

    // Control: input and output valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (step) begin
                r_in_vld <= 1'b0;
            end
            if (step && is_nul) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: capture the character, hold the result until taken.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_char <= i_char_in;
        end
        if (step && is_nul) begin
            r_value    <= n_value;
            r_error    <= n_error;
            r_overflow <= n_overflow;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_value     = r_value;
    assign o_error     = r_error;
    assign o_overflow  = r_overflow;

endmodule
